@@ rtl/spd_pkg.sv @@
// shared types and constants for the serial packet deframer
`default_nettype none

package spd_pkg;

    localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;
    localparam logic [3:0] EXT_LEN_CODE   = 4'h0;
    localparam logic [3:0] MIN_SHORT_LEN  = 4'd2;
    localparam logic [7:0] EXT_LEN_POS    = 8'd2;
    localparam logic [7:0] MIN_EXT_LEN    = 8'd2;
    localparam logic [3:0] MAX_LEN_RESET  = 4'hF;
    localparam logic [3:0] PKT_ID_RESET   = 4'h0;

    typedef enum logic [0:0] {
        CFG_PKT_ID  = 1'b0,
        CFG_MAX_LEN = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAT_BUSY    = 2'd0,
        STAT_GOOD    = 2'd1,
        STAT_BAD     = 2'd2,
        STAT_BAD_LEN = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        ST_HUNT  = 1'b0,
        ST_FRAME = 1'b1
    } t_state;

    typedef struct packed {
        logic [3:0] pkt_id;
        logic [3:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        t_status    frame_status;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/spd_rx_if.sv @@
// received byte channel
`default_nettype none

interface spd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/spd_res_if.sv @@
// frame byte result channel
`default_nettype none

interface spd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [7:0] byte_index;
    logic       frame_end;
    logic [1:0] frame_status;

    modport source (output valid, output frame_byte, output byte_index,
                    output frame_end, output frame_status, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input frame_end, input frame_status, output ready);
endinterface

`default_nettype wire

@@ rtl/spd_cfg_regs.sv @@
// configuration registers of the deframer
`default_nettype none

module spd_cfg_regs (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [0:0]            i_cfg_idx,
    input  wire logic [3:0]            i_cfg_wdata,
    output spd_pkg::t_cfg              o_cfg
);
    import spd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pkt_id  <= PKT_ID_RESET;
            r_cfg.max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PKT_ID:  r_cfg.pkt_id  <= i_cfg_wdata;
                CFG_MAX_LEN: r_cfg.max_len <= i_cfg_wdata;
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/spd_frame_core.sv @@
// input register, frame tracking state and result register
`default_nettype none

module spd_frame_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spd_pkg::t_cfg i_cfg,
    spd_rx_if.sink             i_rx,
    spd_res_if.source          o_res
);
    import spd_pkg::*;

    logic       r_s1_valid, n_s1_valid;
    logic [7:0] r_s1_byte;

    t_state     r_state, n_state;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sum, n_sum;
    logic       r_ext, n_ext;

    logic       r_out_valid, n_out_valid;
    t_result    r_out, n_out;

    logic       in_xfer;
    logic       adv;
    logic       has_res;

    // header decode
    logic [3:0] hdr_len;
    logic       hdr_id_ok;
    logic       hdr_short;
    logic       hdr_ext;
    logic       hdr_take;

    // in-frame decode
    logic       ext_len_byte;
    logic       ext_len_bad;
    logic [7:0] eff_len;
    logic       at_end;
    logic [7:0] expect_sum;

    assign in_xfer    = i_rx.valid && i_rx.ready;
    assign adv        = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_s1_valid || adv;
    assign n_s1_valid = in_xfer || (r_s1_valid && !adv);

    assign hdr_len   = 4'((r_s1_byte & LO_NIBBLE_MASK));
    assign hdr_id_ok = 4'((r_s1_byte & HI_NIBBLE_MASK) >> 4) == i_cfg.pkt_id;
    assign hdr_short = (hdr_len >= MIN_SHORT_LEN) && (hdr_len <= i_cfg.max_len);
    assign hdr_ext   = hdr_len == EXT_LEN_CODE;
    assign hdr_take  = hdr_id_ok && (hdr_short || hdr_ext);

    assign ext_len_byte = r_ext && (r_pos == EXT_LEN_POS);
    assign ext_len_bad  = ext_len_byte && (r_s1_byte < MIN_EXT_LEN);
    assign eff_len      = ext_len_byte ? r_s1_byte : r_len;
    assign at_end       = r_pos == eff_len;
    assign expect_sum   = 8'(8'd0 - r_sum);

    // next state
    always_comb begin
        n_state = r_state;
        if (adv) begin
            unique case (r_state)
                ST_HUNT: begin
                    if (hdr_take) n_state = ST_FRAME;
                end
                ST_FRAME: begin
                    if (ext_len_bad || at_end) n_state = ST_HUNT;
                end
                default: n_state = ST_HUNT;
            endcase
        end
    end

    // frame counters and result
    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        n_ext   = r_ext;
        has_res = 1'b0;
        n_out.frame_byte   = r_s1_byte;
        n_out.byte_index   = r_pos;
        n_out.frame_end    = 1'b0;
        n_out.frame_status = STAT_BUSY;
        unique case (r_state)
            ST_HUNT: begin
                n_out.byte_index = 8'd0;
                if (hdr_take) begin
                    has_res = 1'b1;
                    n_pos   = 8'd1;
                    n_sum   = r_s1_byte;
                    n_ext   = hdr_ext;
                    n_len   = hdr_ext ? EXT_LEN_POS : {4'd0, hdr_len};
                end
            end
            ST_FRAME: begin
                has_res = 1'b1;
                if (ext_len_bad || at_end) begin
                    // back to hunting
                    n_pos = 8'd0;
                    n_len = 8'd0;
                    n_sum = 8'd0;
                    n_ext = 1'b0;
                    n_out.frame_end = 1'b1;
                    if (ext_len_bad) begin
                        n_out.frame_status = STAT_BAD_LEN;
                    end else if (r_s1_byte == expect_sum) begin
                        n_out.frame_status = STAT_GOOD;
                    end else begin
                        n_out.frame_status = STAT_BAD;
                    end
                end else begin
                    n_pos = 8'(r_pos + 8'd1);
                    n_sum = 8'(r_sum + r_s1_byte);
                    n_len = eff_len;
                end
            end
            default: has_res = 1'b0;
        endcase
    end

    assign n_out_valid = adv ? has_res : (r_out_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_HUNT;
            r_pos       <= 8'd0;
            r_len       <= 8'd0;
            r_sum       <= 8'd0;
            r_ext       <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
            if (adv) begin
                r_pos <= n_pos;
                r_len <= n_len;
                r_sum <= n_sum;
                r_ext <= n_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_byte <= i_rx.rx_byte;
        end
        if (adv && has_res) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.frame_byte   = r_out.frame_byte;
    assign o_res.byte_index   = r_out.byte_index;
    assign o_res.frame_end    = r_out.frame_end;
    assign o_res.frame_status = r_out.frame_status;

    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HUNT) |-> (r_pos == 8'd0 && r_sum == 8'd0 && !r_ext))
        else $error("counters not cleared while hunting");

    a_frame_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRAME) |-> (r_pos != 8'd0 && r_len >= MIN_EXT_LEN))
        else $error("bad position or length inside a frame");

    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.frame_end == (r_out.frame_status != STAT_BUSY)))
        else $error("frame end and status disagree");

    a_header_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && has_res && r_state == ST_HUNT) |=>
            (r_state == ST_FRAME && r_out.byte_index == 8'd0))
        else $error("accepted header did not open a frame");

    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_state == ST_FRAME && (ext_len_bad || at_end)) |=>
            (r_state == ST_HUNT && r_out_valid && r_out.frame_end))
        else $error("closing byte did not return to hunting");

endmodule

`default_nettype wire

@@ rtl/serial_packet_deframer_unit.sv @@
// serial packet deframer: length-prefixed frame receiver with checksum check
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  i_rx     | in  | valid / ready       | rx_byte[7:0]
//  o_res    | out | valid / ready       | frame_byte, byte_index, frame_end,
//           |     |                     | frame_status[1:0]
//  i_cfg_*  | in  | write enable only   | idx 0 packet id nibble, idx 1 max length
//
// one byte per cycle sustained while o_res is ready: input register, decode and 8-bit
// sum update, then the result register
// synchronous active-low reset returns to hunting with empty registers
// a stalled result holds the result register, the input register still takes
// one more byte; bytes that give no result leave nothing behind
`default_nettype none

module serial_packet_deframer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [3:0] i_cfg_wdata,
    spd_rx_if.sink          i_rx,
    spd_res_if.source       o_res
);
    import spd_pkg::*;

    t_cfg cfg;

    spd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    spd_frame_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_rx    (i_rx),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
